// ===== sv/kmer_approximate_repeat_detect_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the approximate repeat detector
// Implication checks that disappear from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KMER_APPROXIMATE_REPEAT_DETECT_UNIT_DEFINES_SVH
`define KMER_APPROXIMATE_REPEAT_DETECT_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define KARD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define KARD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("next-cycle implication violated");

`else

`define KARD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define KARD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== sv/kard_pkg.sv =====
// ----------------------------------------------------------------------------
// kard_pkg
// Shared constants and types of the approximate repeat detector.
// ----------------------------------------------------------------------------
package kard_pkg;

  // Field and register widths.
  localparam int SYM_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST  = 11'd16;
  localparam logic [CFG_W-1:0] MISMATCH_LIMIT_RST = 11'd0;

  // Default sequence store capacity.
  localparam int MAX_LENGTH_DEF = 1024;

  // Commands to the shared mismatch accumulator.
  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } acc_ctrl_t;

endpackage

// ===== sv/kard_ram.sv =====
// ----------------------------------------------------------------------------
// kard_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kard_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/kard_mac.sv =====
// ----------------------------------------------------------------------------
// kard_mac
// Shared mismatch accumulator: compares two characters and adds or subtracts
// the mismatch bit from a running window sum.
// ----------------------------------------------------------------------------
module kard_mac #(
  parameter int SUM_W = 11
) (
  input  logic                     clk,
  input  kard_pkg::acc_ctrl_t      ctrl,
  input  logic [kard_pkg::SYM_W-1:0] sym_a,
  input  logic [kard_pkg::SYM_W-1:0] sym_b,
  output logic [SUM_W-1:0]         sum
);

  import kard_pkg::*;

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] diff;

  // One mismatch bit per compared pair.
  assign diff = (sym_a != sym_b) ? SUM_W'(1) : SUM_W'(0);

  // Clear, add or remove one position from the window sum.
  always_comb begin
    sum_nxt = sum_r;
    if (ctrl.clear) begin
      sum_nxt = '0;
    end else if (ctrl.add) begin
      sum_nxt = sum_r + diff;
    end else if (ctrl.sub) begin
      sum_nxt = sum_r - diff;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

// ===== sv/kmer_approximate_repeat_detect_unit.sv =====
// Loading accepts one character per cycle; the block is ready in every load cycle.
// After the last character the search runs over each shift: it fills the first
// window sum one position at a time, then checks it and slides the window,
// adding the entering and subtracting the leaving character before each check.
// Each compared pair is read through the registered store read ports.
// rst_n (synchronous, active low) empties the sequence and restores the registers.
// ----------------------------------------------------------------------------
// kmer_approximate_repeat_detect_unit
// Stores a sequence and searches for two windows of length K that differ in at
// most a set number of positions, using one shared mismatch accumulator.
// ----------------------------------------------------------------------------
`include "kmer_approximate_repeat_detect_unit_defines.svh"

module kmer_approximate_repeat_detect_unit #(
  parameter int MAX_LENGTH = kard_pkg::MAX_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kard_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kard_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kard_pkg::SYM_W-1:0]     in_symbol,
  input  logic                           in_final_symbol,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_found,
  output logic                           out_overflow
);

  import kard_pkg::*;

  localparam int AW    = $clog2(MAX_LENGTH);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int EW    = CMP_W + 1;

  // Sequencer states.
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_IRD   = 4'd2;
  localparam logic [3:0] S_IACC  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_ARD   = 4'd5;
  localparam logic [3:0] S_AACC  = 4'd6;
  localparam logic [3:0] S_SRD   = 4'd7;
  localparam logic [3:0] S_SACC  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CFG_W-1:0] win_len_r, win_len_nxt;
  logic [CFG_W-1:0] mis_lim_r, mis_lim_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic [CNT_W-1:0] span_r, span_nxt;
  logic [CNT_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0] a_r, a_nxt;
  logic             found_r, found_nxt;

  acc_ctrl_t        acc_ctrl;
  logic [CNT_W-1:0] sum;
  logic [EW-1:0]    rd_pos;
  logic [AW-1:0]    rd_x;
  logic [AW-1:0]    rd_y;
  logic [SYM_W-1:0] sym_x;
  logic [SYM_W-1:0] sym_y;
  logic             store_room;
  logic             wr_en;
  logic             in_acc;
  logic             out_acc;

  assign store_room = (count_r < CNT_W'(MAX_LENGTH));
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign wr_en      = in_acc && store_room;

  assign in_stall     = (state_r != S_LOAD);
  assign out_valid    = (state_r == S_OUT);
  assign out_found    = found_r;
  assign out_overflow = dropped_r;

  // Second compared position sits one shift further along the sequence.
  assign rd_x = rd_pos[AW-1:0];
  assign rd_y = rd_x + shift_r[AW-1:0];

  // Two copies of the store give the two read ports of each compared pair.
  kard_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LENGTH)
  ) u_store_x (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_symbol),
    .rd_addr (rd_x),
    .rd_data (sym_x)
  );

  kard_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LENGTH)
  ) u_store_y (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_symbol),
    .rd_addr (rd_y),
    .rd_data (sym_y)
  );

  kard_mac #(
    .SUM_W (CNT_W)
  ) u_mac (
    .clk   (clk),
    .ctrl  (acc_ctrl),
    .sym_a (sym_x),
    .sym_b (sym_y),
    .sum   (sum)
  );

  // Configuration register writes.
  always_comb begin
    win_len_nxt = win_len_r;
    mis_lim_nxt = mis_lim_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:  win_len_nxt = cfg_data;
        REG_MISMATCH_LIMIT: mis_lim_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Search sequencer.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    span_nxt    = span_r;
    shift_nxt   = shift_r;
    p_nxt       = p_r;
    a_nxt       = a_r;
    found_nxt   = found_r;
    acc_ctrl    = '0;
    rd_pos      = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (store_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_final_symbol) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (CMP_W'(count_r) <= CMP_W'(win_len_r)) begin
          found_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          span_nxt       = CNT_W'(CMP_W'(count_r) - CMP_W'(win_len_r));
          shift_nxt      = CNT_W'(1);
          p_nxt          = '0;
          a_nxt          = '0;
          acc_ctrl.clear = 1'b1;
          state_nxt      = (win_len_r == '0) ? S_CHECK : S_IRD;
        end
      end
      S_IRD: begin
        rd_pos    = EW'(p_r);
        state_nxt = S_IACC;
      end
      S_IACC: begin
        acc_ctrl.add = 1'b1;
        if (CMP_W'(p_r) + CMP_W'(1) == CMP_W'(win_len_r)) begin
          state_nxt = S_CHECK;
        end else begin
          p_nxt     = p_r + CNT_W'(1);
          state_nxt = S_IRD;
        end
      end
      S_CHECK: begin
        if (CMP_W'(sum) <= CMP_W'(mis_lim_r)) begin
          found_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (a_r == span_r - shift_r) begin
          if (shift_r == span_r) begin
            found_nxt = 1'b0;
            state_nxt = S_OUT;
          end else begin
            shift_nxt      = shift_r + CNT_W'(1);
            p_nxt          = '0;
            a_nxt          = '0;
            acc_ctrl.clear = 1'b1;
            state_nxt      = S_IRD;
          end
        end else begin
          a_nxt     = a_r + CNT_W'(1);
          state_nxt = S_ARD;
        end
      end
      S_ARD: begin
        // Character entering the window.
        rd_pos    = EW'(a_r) + EW'(win_len_r) - EW'(1);
        state_nxt = S_AACC;
      end
      S_AACC: begin
        acc_ctrl.add = 1'b1;
        state_nxt    = S_SRD;
      end
      S_SRD: begin
        // Character leaving the window.
        rd_pos    = EW'(a_r) - EW'(1);
        state_nxt = S_SACC;
      end
      S_SACC: begin
        acc_ctrl.sub = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_OUT: begin
        if (out_acc) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      win_len_r <= WINDOW_LENGTH_RST;
      mis_lim_r <= MISMATCH_LIMIT_RST;
      count_r   <= '0;
      dropped_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      win_len_r <= win_len_nxt;
      mis_lim_r <= mis_lim_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      found_r   <= found_nxt;
    end
  end

  // Search position registers.
  always_ff @(posedge clk) begin
    span_r  <= span_nxt;
    shift_r <= shift_nxt;
    p_r     <= p_nxt;
    a_r     <= a_nxt;
  end

  // A request that finds the store full marks the sequence as truncated.
  `KARD_ASSERT_NEXT(a_drop_full, clk, rst_n, in_acc && !store_room, dropped_r)

  // A delivered result leaves an empty sequence behind.
  `KARD_ASSERT_NEXT(a_out_clear, clk, rst_n, out_acc, (count_r == '0) && !dropped_r)

  // A window sum never counts more mismatches than the window has positions.
  `KARD_ASSERT_IMPLY(a_sum_bound, clk, rst_n, state_r == S_CHECK,
                     CMP_W'(sum) <= CMP_W'(win_len_r))

  // The shift stays inside the searched span while the search runs.
  `KARD_ASSERT_IMPLY(a_shift_range, clk, rst_n,
                     (state_r != S_LOAD) && (state_r != S_START) && (state_r != S_OUT),
                     (shift_r != '0) && (shift_r <= span_r))

endmodule
